// ----- sv/ccd_pkg.sv -----
package ccd_pkg;

  // Container layout
  localparam logic [31:0] HdrLen = 32'd16;
  localparam logic [3:0]  SigLen = 4'd10;

  // Expected version header, in stream order
  localparam logic [7:0] HdrTag [16] = '{
    8'h4D, 8'h41, 8'h58, 8'h46, 8'h49, 8'h4C, 8'h45, 8'h20,
    8'h43, 8'h33, 8'h20, 8'h30, 8'h30, 8'h30, 8'h30, 8'h31
  };

  // Result event codes
  localparam logic [2:0] EV_HDR_OK  = 3'd0;
  localparam logic [2:0] EV_VER_DIF = 3'd1;
  localparam logic [2:0] EV_BAD_SIG = 3'd2;
  localparam logic [2:0] EV_SMALL   = 3'd3;
  localparam logic [2:0] EV_CHUNK   = 3'd4;
  localparam logic [2:0] EV_OOB     = 3'd5;
  localparam logic [2:0] EV_PAYLOAD = 3'd6;
  localparam logic [2:0] EV_END     = 3'd7;

  localparam int unsigned ResDepth = 2;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK_HDR,
    PH_PAYLOAD,
    PH_SKIP,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [31:0] chunk_type;
    logic [31:0] chunk_offset;
    logic [31:0] chunk_length;
    logic [7:0]  payload_byte;
    logic        container_valid;
    logic        last_of_run;
  } res_t;

endpackage

// ----- sv/ccd_if.sv -----
interface ccd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface ccd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [31:0] chunk_type;
  logic [31:0] chunk_offset;
  logic [31:0] chunk_length;
  logic [7:0]  payload_byte;
  logic        container_valid;
  logic        last_of_run;

  modport source (
    output valid, output event_res, output chunk_type, output chunk_offset,
    output chunk_length, output payload_byte, output container_valid,
    output last_of_run, input ready
  );
  modport sink (
    input valid, input event_res, input chunk_type, input chunk_offset,
    input chunk_length, input payload_byte, input container_valid,
    input last_of_run, output ready
  );
endinterface

interface ccd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] container_length;

  modport source (output valid, output container_length, input ready);
  modport sink (input valid, input container_length, output ready);
endinterface

// ----- sv/ccd_parser.sv -----
module ccd_parser
  import ccd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_len_i,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  output res_t        res0_o,
  output res_t        res1_o,
  output logic [1:0]  n_res_o
);

  phase_e      phase_q, phase_d;
  logic [32:0] pos1_q, pos1_d;
  logic [2:0]  fc_q, fc_d;
  logic [31:0] id_q, id_d;
  logic [31:0] size_q, size_d;
  logic [31:0] rem_q, rem_d;
  logic        sig_q, sig_d;
  logic        ver_q, ver_d;
  logic [31:0] len_q;

  logic [3:0]  hdr_idx;
  logic        mismatch, sig_n, ver_n, too_small, hdr_last, end_hit, in_bounds;
  logic [31:0] size_full, rem_dec;
  logic [32:0] stop;

  logic        prim_vld, forced_end, no_check, norm_end, end_vld;
  res_t        prim, end_res;

  assign hdr_idx   = pos1_q[3:0] - 4'd1;
  assign mismatch  = byte_i != HdrTag[hdr_idx];
  assign sig_n     = sig_q & ~(mismatch & (hdr_idx < SigLen));
  assign ver_n     = ver_q & ~mismatch;
  assign too_small = len_q < HdrLen;
  assign hdr_last  = hdr_idx == 4'd15;
  assign end_hit   = pos1_q >= {1'b0, len_q};
  assign size_full = {byte_i, size_q[23:0]};
  assign stop      = {1'b0, pos1_q[31:0]} + {1'b0, size_full};
  assign in_bounds = stop <= {1'b0, len_q};
  assign rem_dec   = (rem_q == 32'd0) ? 32'd0 : rem_q - 32'd1;

  // Result selection
  always_comb begin
    prim       = '0;
    prim_vld   = 1'b0;
    forced_end = 1'b0;
    no_check   = 1'b0;
    case (phase_q)
      PH_HEADER: begin
        if (too_small) begin
          prim_vld       = 1'b1;
          prim.event_res = EV_SMALL;
          forced_end     = 1'b1;
          no_check       = 1'b1;
        end else if (hdr_last) begin
          prim_vld = 1'b1;
          if (!sig_n) begin
            prim.event_res = EV_BAD_SIG;
            forced_end     = 1'b1;
            no_check       = 1'b1;
          end else begin
            prim.event_res = ver_n ? EV_HDR_OK : EV_VER_DIF;
          end
        end
      end
      PH_CHUNK_HDR: begin
        if (fc_q == 3'd7) begin
          prim_vld          = 1'b1;
          prim.event_res    = in_bounds ? EV_CHUNK : EV_OOB;
          prim.chunk_type   = id_q;
          prim.chunk_offset = pos1_q[31:0];
          prim.chunk_length = size_full;
        end
      end
      PH_PAYLOAD: begin
        prim_vld          = 1'b1;
        prim.event_res    = EV_PAYLOAD;
        prim.payload_byte = byte_i;
      end
      PH_SKIP: begin
        prim_vld = 1'b0;
      end
      default: begin
        no_check = 1'b1;
      end
    endcase

    norm_end                = ~no_check & end_hit;
    end_vld                 = forced_end | norm_end;
    end_res                 = '0;
    end_res.event_res       = EV_END;
    end_res.container_valid = norm_end;
    end_res.last_of_run     = 1'b1;

    n_res_o = {1'b0, prim_vld} + {1'b0, end_vld};
    res1_o  = end_res;
    if (prim_vld) begin
      res0_o             = prim;
      res0_o.last_of_run = ~end_vld;
    end else begin
      res0_o = end_res;
    end
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    pos1_d  = pos1_q;
    fc_d    = fc_q;
    id_d    = id_q;
    size_d  = size_q;
    rem_d   = rem_q;
    sig_d   = sig_q;
    ver_d   = ver_q;
    case (phase_q)
      PH_HEADER: begin
        if (too_small) begin
          phase_d = PH_DONE;
        end else begin
          sig_d = sig_n;
          ver_d = ver_n;
          if (hdr_last) begin
            phase_d = sig_n ? PH_CHUNK_HDR : PH_DONE;
            fc_d    = 3'd0;
          end
        end
      end
      PH_CHUNK_HDR: begin
        fc_d = fc_q + 3'd1;
        if (!fc_q[2]) begin
          id_d = id_q | ({24'd0, byte_i} << {fc_q[1:0], 3'd0});
        end else begin
          size_d = size_q | ({24'd0, byte_i} << {fc_q[1:0], 3'd0});
        end
        if (fc_q == 3'd7) begin
          id_d   = '0;
          size_d = '0;
          if (in_bounds) begin
            rem_d   = size_full;
            phase_d = (size_full == 32'd0) ? PH_CHUNK_HDR : PH_PAYLOAD;
          end else begin
            phase_d = PH_SKIP;
          end
        end
      end
      PH_PAYLOAD: begin
        rem_d = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_d = PH_CHUNK_HDR;
          fc_d    = 3'd0;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
    if (!no_check) begin
      pos1_d = pos1_q + 33'd1;
    end
    if (norm_end) begin
      phase_d = PH_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos1_q  <= 33'd1;
      fc_q    <= '0;
      id_q    <= '0;
      size_q  <= '0;
      rem_q   <= '0;
      sig_q   <= 1'b1;
      ver_q   <= 1'b1;
      len_q   <= '0;
    end else if (cfg_we_i) begin
      // restart on every length write
      phase_q <= PH_HEADER;
      pos1_q  <= 33'd1;
      fc_q    <= '0;
      id_q    <= '0;
      size_q  <= '0;
      rem_q   <= '0;
      sig_q   <= 1'b1;
      ver_q   <= 1'b1;
      len_q   <= cfg_len_i;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos1_q  <= pos1_d;
      fc_q    <= fc_d;
      id_q    <= id_d;
      size_q  <= size_d;
      rem_q   <= rem_d;
      sig_q   <= sig_d;
      ver_q   <= ver_d;
    end
  end

endmodule

// ----- sv/ccd_res_queue.sv -----
module ccd_res_queue
  import ccd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_n_i,
  input  res_t       push0_i,
  input  res_t       push1_i,
  input  logic       pop_i,
  output res_t       head_o,
  output logic       head_vld_o,
  output logic [1:0] count_o
);

  res_t       slot_q [ResDepth];
  res_t       slot_d [ResDepth];
  logic [1:0] cnt_q, cnt_d, base;

  assign head_o     = slot_q[0];
  assign head_vld_o = cnt_q != 2'd0;
  assign count_o    = cnt_q;

  always_comb begin
    base  = cnt_q - {1'b0, pop_i & head_vld_o};
    cnt_d = base + push_n_i;
    // shift out the popped head, then append the new requests
    if (base != 2'd0) begin
      slot_d[0] = pop_i ? slot_q[1] : slot_q[0];
    end else begin
      slot_d[0] = push0_i;
    end
    case (base)
      2'd2:    slot_d[1] = slot_q[1];
      2'd1:    slot_d[1] = push0_i;
      default: slot_d[1] = push1_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

endmodule

// ----- sv/chunk_container_deframer.sv -----
// Channel  | Dir | Payload                                  | Transfer
// ---------+-----+------------------------------------------+------------------
// cfg_i    | in  | container_length                         | valid && ready
// in_i     | in  | data_byte                                | valid && ready
// out_o    | out | event_res, chunk_type, chunk_offset,     | valid && ready
//          |     | chunk_length, payload_byte,              |
//          |     | container_valid, last_of_run             |
//
// One byte a cycle while the result queue has room: a byte lands in the input
// register, is parsed there and its zero, one or two results go into a two-entry
// result queue. A byte that causes two results occupies the single output port
// for both of them; that port sets the rate for such bytes.
// Reset clears the parse state and the queue; a length write restarts parsing.
// A stalled output backs up into the queue and then holds the input register.
module chunk_container_deframer
  import ccd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ccd_cfg_if.sink   cfg_i,
  ccd_in_if.sink    in_i,
  ccd_out_if.source out_o
);

  logic       vld_q;
  logic [7:0] byte_q;
  logic       go;
  logic       in_acc;
  logic       pop;
  logic [1:0] n_res;
  logic [1:0] cnt;
  logic [1:0] push_n;
  logic       head_vld;
  res_t       res0, res1, head;

  // The length register takes every write at once
  assign cfg_i.ready = 1'b1;

  // Advance the held byte once the queue has room for all its results.
  // Room is judged on the registered count, so input ready never waits
  // combinationally on output ready.
  assign go       = vld_q && (n_res <= (2'd2 - cnt));
  assign in_i.ready = !vld_q || go;
  assign in_acc   = in_i.valid && in_i.ready;
  assign push_n   = go ? n_res : 2'd0;
  assign pop      = out_o.valid && out_o.ready;

  // Input register: hold the byte until the parser consumes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_acc) begin
      vld_q <= 1'b1;
    end else if (go) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= in_i.data_byte;
    end
  end

  ccd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_i.valid),
    .cfg_len_i (cfg_i.container_length),
    .step_i    (go),
    .byte_i    (byte_q),
    .res0_o    (res0),
    .res1_o    (res1),
    .n_res_o   (n_res)
  );

  ccd_res_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_n_i   (push_n),
    .push0_i    (res0),
    .push1_i    (res1),
    .pop_i      (pop),
    .head_o     (head),
    .head_vld_o (head_vld),
    .count_o    (cnt)
  );

  // Drive the output request from the queue head
  assign out_o.valid           = head_vld;
  assign out_o.event_res       = head.event_res;
  assign out_o.chunk_type      = head.chunk_type;
  assign out_o.chunk_offset    = head.chunk_offset;
  assign out_o.chunk_length    = head.chunk_length;
  assign out_o.payload_byte    = head.payload_byte;
  assign out_o.container_valid = head.container_valid;
  assign out_o.last_of_run     = head.last_of_run;

`ifndef SYNTHESIS
  // The queue never holds more than two results
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt <= 2'd2)
    else $error("result queue overflow");

  // A result that is not the last of its byte is followed by its partner
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !out_o.last_of_run) |=> out_o.valid)
    else $error("second result of a byte missing");

  // The end result always closes its byte's run
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.event_res == EV_END) |-> out_o.last_of_run)
    else $error("end result not last of run");
`endif

endmodule

// ----- verif/ccd_checker.sv -----
`timescale 1ns / 100ps

module ccd_checker
  import ccd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ccd_cfg_if          cfg_i,
  ccd_in_if           in_i,
  ccd_out_if          out_i,
  output int unsigned fail_count_o,
  output int unsigned backlog_o
);

  res_t        results_q[$];
  int unsigned fail_count = 0;
  int unsigned backlog    = 0;

  // Parser image
  logic [31:0] length_q;
  phase_e      phase_q;
  logic [31:0] pos_q;
  logic [2:0]  field_q;
  logic [31:0] id_q;
  logic [31:0] size_q;
  logic [31:0] remain_q;
  logic        sig_ok_q;
  logic        ver_ok_q;

  assign fail_count_o = fail_count;
  assign backlog_o    = backlog;

  function automatic res_t make_res(input logic [2:0] ev, input logic [31:0] id,
                                    input logic [31:0] off, input logic [31:0] len,
                                    input logic [7:0] pay, input logic vld);
    res_t r;
    r.event_res       = ev;
    r.chunk_type      = id;
    r.chunk_offset    = off;
    r.chunk_length    = len;
    r.payload_byte    = pay;
    r.container_valid = vld;
    r.last_of_run     = 1'b0;
    return r;
  endfunction

  function automatic bit field_bad(input string name, input logic [31:0] want,
                                   input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
    return want !== got;
  endfunction

  // Append one predicted result at the tail.
  task automatic queue_res(input res_t r);
    results_q = {results_q, r};
  endtask

  task automatic restart_parse();
    phase_q  = PH_HEADER;
    pos_q    = '0;
    field_q  = '0;
    id_q     = '0;
    size_q   = '0;
    remain_q = '0;
    sig_ok_q = 1'b1;
    ver_ok_q = 1'b1;
  endtask

  // Advance the parser by one container byte and queue what it reports.
  task automatic parse_byte(input logic [7:0] b);
    logic [31:0] p;
    logic [31:0] off;
    logic [32:0] stop;
    logic        to_end;
    int unsigned n;
    res_t        r;
    p      = pos_q;
    to_end = 1'b1;
    n      = 0;
    if (phase_q == PH_DONE) return;
    case (phase_q)
      PH_HEADER: begin
        if (length_q < HdrLen) begin
          queue_res(make_res(EV_SMALL, '0, '0, '0, '0, 1'b0));
          queue_res(make_res(EV_END, '0, '0, '0, '0, 1'b0));
          n       = 2;
          phase_q = PH_DONE;
          to_end  = 1'b0;
        end else begin
          if (b != HdrTag[p[3:0]]) begin
            ver_ok_q = 1'b0;
            if (p[3:0] < SigLen) sig_ok_q = 1'b0;
          end
          if ({28'd0, p[3:0]} == HdrLen - 32'd1) begin
            if (!sig_ok_q) begin
              queue_res(make_res(EV_BAD_SIG, '0, '0, '0, '0, 1'b0));
              queue_res(make_res(EV_END, '0, '0, '0, '0, 1'b0));
              n       = 2;
              phase_q = PH_DONE;
              to_end  = 1'b0;
            end else begin
              queue_res(make_res(ver_ok_q ? EV_HDR_OK : EV_VER_DIF,
                                 '0, '0, '0, '0, 1'b0));
              n       = 1;
              phase_q = PH_CHUNK_HDR;
              field_q = '0;
            end
          end
        end
      end
      PH_CHUNK_HDR: begin
        // id in fields 0..3, size in 4..7, both little-endian
        if (field_q < 3'd4) id_q |= 32'(b) << {field_q[1:0], 3'b000};
        else size_q |= 32'(b) << {field_q[1:0], 3'b000};
        field_q = field_q + 3'd1;
        if (field_q == 3'd0) begin
          off  = p + 32'd1;
          stop = {1'b0, off} + {1'b0, size_q};
          if (stop <= {1'b0, length_q}) begin
            queue_res(make_res(EV_CHUNK, id_q, off, size_q, '0, 1'b0));
            remain_q = size_q;
            phase_q  = (size_q == '0) ? PH_CHUNK_HDR : PH_PAYLOAD;
          end else begin
            queue_res(make_res(EV_OOB, id_q, off, size_q, '0, 1'b0));
            phase_q = PH_SKIP;
          end
          n      = 1;
          id_q   = '0;
          size_q = '0;
        end
      end
      PH_PAYLOAD: begin
        queue_res(make_res(EV_PAYLOAD, '0, '0, '0, b, 1'b0));
        n = 1;
        if (remain_q != '0) remain_q = remain_q - 32'd1;
        if (remain_q == '0) begin
          phase_q = PH_CHUNK_HDR;
          field_q = '0;
        end
      end
      default: ;
    endcase
    if (to_end) begin
      pos_q = p + 32'd1;
      if ({1'b0, p} + 33'd1 >= {1'b0, length_q}) begin
        queue_res(make_res(EV_END, '0, '0, '0, '0, 1'b1));
        n       = n + 1;
        phase_q = PH_DONE;
      end
    end
    if (n > 0) begin
      r = results_q[results_q.size() - 1];
      r.last_of_run = 1'b1;
      results_q[results_q.size() - 1] = r;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    bit   bad;
    if (!rst_ni) begin
      length_q = '0;
      restart_parse();
      results_q.delete();
    end else begin
      if (out_i.valid && out_i.ready) begin
        got.event_res       = out_i.event_res;
        got.chunk_type      = out_i.chunk_type;
        got.chunk_offset    = out_i.chunk_offset;
        got.chunk_length    = out_i.chunk_length;
        got.payload_byte    = out_i.payload_byte;
        got.container_valid = out_i.container_valid;
        got.last_of_run     = out_i.last_of_run;
        if (results_q.size() == 0) begin
          $display("%0t: expected no result, got event %0d type %h off %h len %h byte %h",
                   $time, got.event_res, got.chunk_type, got.chunk_offset,
                   got.chunk_length, got.payload_byte);
          fail_count++;
        end else begin
          want = results_q.pop_front();
          bad  = 1'b0;
          bad |= field_bad("event_res", 32'(want.event_res), 32'(got.event_res));
          bad |= field_bad("chunk_type", want.chunk_type, got.chunk_type);
          bad |= field_bad("chunk_offset", want.chunk_offset, got.chunk_offset);
          bad |= field_bad("chunk_length", want.chunk_length, got.chunk_length);
          bad |= field_bad("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
          bad |= field_bad("container_valid", 32'(want.container_valid),
                           32'(got.container_valid));
          bad |= field_bad("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
          if (bad) fail_count++;
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        length_q = cfg_i.container_length;
        restart_parse();
      end
      if (in_i.valid && in_i.ready) parse_byte(in_i.data_byte);
    end
    backlog = results_q.size();
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import ccd_pkg::*;

  // Shapes of the 16-byte version header
  typedef enum int {
    HDR_EXACT,
    HDR_VERSION,
    HDR_BADSIG,
    HDR_NOISE
  } hdr_kind_e;

  // Receiver back-pressure styles
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_RHYTHM
  } stall_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  ccd_cfg_if cfg_if ();
  ccd_in_if  in_if ();
  ccd_out_if out_if ();

  int unsigned fail_count;
  int unsigned backlog;

  logic [7:0]  image_q[$];  // container bytes in stream order
  int unsigned burst_left;
  int unsigned bytes_fed;   // bytes the parser actually consumes
  bit          in_up;       // input valid is currently raised

  chunk_container_deframer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  ccd_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_if),
    .in_i         (in_if),
    .out_i        (out_if),
    .fail_count_o (fail_count),
    .backlog_o    (backlog)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop: well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: switch between back-pressure styles at random intervals.
  initial begin
    stall_e      mode;
    int unsigned left;
    out_if.ready = 1'b0;
    mode         = RX_OPEN;
    left         = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = stall_e'($urandom_range(0, 3));
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        RX_OPEN:   out_if.ready <= 1'b1;
        RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_if.ready <= ($urandom_range(0, 7) == 0);
        default:   out_if.ready <= (left % 4 != 3);
      endcase
    end
  end

  // Drop the input request, unless it is already down.
  task automatic hold_input();
    if (in_up) begin
      in_if.valid <= 1'b0;
      in_up = 1'b0;
    end
  endtask

  // Offer one byte, wait for the handshake, then maybe leave a gap.
  // Called and returns at a falling edge; valid stays up between
  // back-to-back requests so it is never lowered and raised in one step.
  task automatic send_byte(input logic [7:0] b);
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_up = 1'b1;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      hold_input();
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 16);
    end
  endtask

  // Hold the sender until every predicted result has been taken, then give
  // a byte that reports nothing time to leave the pipeline.
  task automatic drain();
    hold_input();
    while (backlog != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write the length register on an idle block; this restarts parsing.
  task automatic write_length(input logic [31:0] len);
    drain();
    cfg_if.valid            <= 1'b1;
    cfg_if.container_length <= len;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Append one byte to the container image.
  task automatic append_byte(input logic [7:0] b);
    image_q = {image_q, b};
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) append_byte(w[8*k +: 8]);
  endtask

  task automatic put_header(input hdr_kind_e kind);
    logic [7:0]  tag [16];
    int unsigned j;
    foreach (tag[k]) tag[k] = HdrTag[k];
    case (kind)
      HDR_VERSION: begin
        // Damage only the version suffix: a warning, still accepted
        repeat ($urandom_range(1, 3)) begin
          j = $urandom_range(10, 15);
          tag[j] ^= 8'($urandom_range(1, 255));
        end
      end
      HDR_BADSIG: begin
        j = $urandom_range(0, 9);
        tag[j] ^= 8'($urandom_range(1, 255));
        if ($urandom_range(0, 1) == 1) tag[15] ^= 8'h01;
      end
      HDR_NOISE: begin
        foreach (tag[k]) tag[k] = 8'($urandom_range(0, 255));
      end
      default: ;
    endcase
    foreach (tag[k]) append_byte(tag[k]);
  endtask

  // Chunk: id, little-endian size, then npay random payload bytes.
  task automatic put_chunk(input logic [31:0] id, input logic [31:0] size,
                           input int unsigned npay);
    put_word(id);
    put_word(size);
    repeat (npay) append_byte(8'($urandom_range(0, 255)));
  endtask

  // Stream the image up to the container end; extra bytes go past the end
  // and must be ignored.
  task automatic stream_image(input logic [31:0] len, input int unsigned extra);
    int unsigned n;
    n = image_q.size();
    if (len < HdrLen) n = (n > 0) ? 1 : 0;  // too small: the first byte ends it
    else if (len < n) n = len;
    for (int i = 0; i < n; i++) begin
      send_byte(image_q[i]);
      if ($urandom_range(0, 299) == 0) drain();
    end
    bytes_fed += n;
    repeat (extra) send_byte(8'($urandom_range(0, 255)));
  endtask

  // One container with random header, chunks and tail; mostly well formed.
  task automatic random_container();
    hdr_kind_e   kind;
    int unsigned roll;
    int unsigned size;
    logic [31:0] len;
    int unsigned extra;
    image_q.delete();
    roll = $urandom_range(0, 99);
    if (roll < 70) kind = HDR_EXACT;
    else if (roll < 82) kind = HDR_VERSION;
    else if (roll < 94) kind = HDR_BADSIG;
    else kind = HDR_NOISE;
    put_header(kind);
    repeat ($urandom_range(0, 5)) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) size = 0;
      else if (roll < 70) size = $urandom_range(1, 8);
      else if (roll < 92) size = $urandom_range(9, 40);
      else size = $urandom;  // almost surely past the end
      put_chunk($urandom, size, (size > 40) ? $urandom_range(0, 6) : size);
    end
    // Trailing bytes too few for a full chunk header
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 7)) append_byte(8'($urandom_range(0, 255)));
    end
    roll = $urandom_range(0, 99);
    if (roll < 72) len = 32'(image_q.size());
    else if (roll < 87) len = $urandom_range(16, image_q.size());
    else if (roll < 93) len = $urandom_range(0, 15);
    else len = 32'(image_q.size()) + $urandom_range(1, 20);  // end never reached
    extra = 0;
    if (len <= image_q.size() && $urandom_range(0, 3) == 0) extra = $urandom_range(1, 4);
    write_length(len);
    stream_image(len, extra);
  endtask

  initial begin
    cfg_if.valid            = 1'b0;
    cfg_if.container_length = '0;
    in_if.valid             = 1'b0;
    in_if.data_byte         = '0;
    rst_ni                  = 1'b0;
    in_up                   = 1'b0;
    bytes_fed               = 0;
    burst_left              = 1;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Length 0 out of reset: too small on the first byte, the next ignored.
    send_byte(8'h00);
    send_byte(8'hFF);
    bytes_fed += 1;

    // Largest length that is still too small.
    write_length(32'd15);
    send_byte(8'hA5);
    bytes_fed += 1;

    // Largest length: exact header and an empty chunk, a pause until all
    // results are in, then a chunk running past the end and skipped bytes.
    write_length(32'hFFFF_FFFF);
    image_q.delete();
    put_header(HDR_EXACT);
    put_chunk(32'h0000_0000, 32'd0, 0);
    stream_image(32'hFFFF_FFFF, 0);
    drain();
    image_q.delete();
    put_chunk(32'hFFFF_FFFF, 32'hFFFF_FFF0, 2);
    stream_image(32'hFFFF_FFFF, 0);

    while (bytes_fed < 1300) random_container();

    // Wait out the last results, bounded, then let the pipeline settle.
    hold_input();
    for (int w = 0; w < 20000 && backlog != 0; w++) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (backlog != 0) $display("%0t: %0d expected results never came", $time, backlog);
    if (fail_count == 0 && backlog == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
